// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. They expect clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tair_pkg.sv =====
// ---------------------------------------------------------------------------
// tair_pkg
// Types, codes and helpers for the three-address instruction executor.
// ---------------------------------------------------------------------------
package tair_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;
	localparam int RED_W  = 12;
	localparam logic [CNT_W-1:0] CNT_LAST = 5'd31;

	// instruction modes
	typedef enum logic [2:0] {
		MODE_STORE = 3'd0,
		MODE_LDVAR = 3'd1,
		MODE_LDIMM = 3'd2,
		MODE_LABEL = 3'd3,
		MODE_GOTO  = 3'd4,
		MODE_BNZ   = 3'd5,
		MODE_BZ    = 3'd6,
		MODE_ALU   = 3'd7
	} mode_t;

	// alu operations
	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MOD = 4'd4,
		OP_LT  = 4'd5,
		OP_GT  = 4'd6,
		OP_EQ  = 4'd7,
		OP_NE  = 4'd8,
		OP_LE  = 4'd9,
		OP_GE  = 4'd10
	} alu_op_t;

	// sequencer states
	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_LOAD   = 9'b000000100,
		ST_NEGA   = 9'b000001000,
		ST_NEGB   = 9'b000010000,
		ST_MUL    = 9'b000100000,
		ST_DIV    = 9'b001000000,
		ST_FIX    = 9'b010000000,
		ST_FINISH = 9'b100000000
	} state_t;

	// 8-bit index reduced modulo a store depth, restoring compare-subtract
	function automatic logic [RED_W-1:0] idx_mod(input logic [7:0] v, input int unsigned n);
		logic [19:0] r;
		logic [19:0] d;
		r = {12'b0, v};
		for (int i = 7; i >= 0; i--) begin
			d = 20'(n) << i;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[RED_W-1:0];
	endfunction

endpackage

// ===== src/three_address_ir_executor_core.sv =====
// ---------------------------------------------------------------------------
// three_address_ir_executor_core
// Runs one decoded three-address instruction per request against a temp
// register file and a variable store, returning next pc, written value and
// a divide-by-zero fault.
// ---------------------------------------------------------------------------
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | mode alu_op dest_temp src_temp_a src_temp_b
//           |                      | var_slot immediate current_pc jump_target
//   out     | out_valid / out_ready| next_pc written_value fault
//
// Most instructions pass from acceptance through the load and finish states to the
// result register; mul iterates shift-add over the shared adder, and div and mod
// run two sign fix-ups, 32 restoring steps and a final negate on the same adder.
// After reset a clearing pass over max(NUM_TEMPS, NUM_VARS) addresses zeroes both
// stores; in_ready stays low during it.
// A new request is taken while a result waits in the output register; the
// sequencer holds in its last state only when that register is still full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module three_address_ir_executor_core
	import tair_pkg::*;
#(
	parameter int NUM_TEMPS = 256,
	parameter int NUM_VARS  = 256,
	parameter int PC_WIDTH  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 mode,
	input  logic [3:0]                 alu_op,
	input  logic [7:0]                 dest_temp,
	input  logic [7:0]                 src_temp_a,
	input  logic [7:0]                 src_temp_b,
	input  logic [7:0]                 var_slot,
	input  logic [30:0]                immediate,
	input  logic [PC_WIDTH-1:0]        current_pc,
	input  logic [PC_WIDTH-1:0]        jump_target,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [PC_WIDTH-1:0]        next_pc,
	output logic signed [DATA_W-1:0]   written_value,
	output logic                       fault
);

	localparam int TA_W      = $clog2(NUM_TEMPS);
	localparam int VA_W      = $clog2(NUM_VARS);
	localparam int CLR_DEPTH = (NUM_TEMPS > NUM_VARS) ? NUM_TEMPS : NUM_VARS;
	localparam int CLR_W     = $clog2(CLR_DEPTH);
	localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_DEPTH - 1);
	localparam logic [CLR_W:0]   TEMPS_LIM = (CLR_W+1)'(NUM_TEMPS);
	localparam logic [CLR_W:0]   VARS_LIM  = (CLR_W+1)'(NUM_VARS);

	// storage
	logic [DATA_W-1:0] temp_mem [NUM_TEMPS];
	logic [DATA_W-1:0] var_mem  [NUM_VARS];

	state_t              state_q;
	logic [CLR_W-1:0]    clr_cnt_q;
	logic [CNT_W-1:0]    cnt_q;

	// captured request
	mode_t               mode_q;
	alu_op_t             op_q;
	logic [TA_W-1:0]     td_q;
	logic [VA_W-1:0]     vs_q;
	logic [30:0]         imm_q;
	logic [PC_WIDTH-1:0] pc_q;
	logic [PC_WIDTH-1:0] tgt_q;

	// read data
	logic [DATA_W-1:0]   rd_a_q;
	logic [DATA_W-1:0]   rd_b_q;
	logic [DATA_W-1:0]   rd_v_q;

	// datapath
	logic [DATA_W-1:0]   a_q;
	logic [DATA_W-1:0]   b_q;
	logic [DATA_W-1:0]   acc_q;
	logic [DATA_W-1:0]   quo_q;
	logic                sign_a_q;
	logic                sign_b_q;

	// pending result
	logic [PC_WIDTH-1:0] res_pc_q;
	logic [DATA_W-1:0]   res_val_q;
	logic                res_fault_q;
	logic                wr_temp_q;
	logic                wr_var_q;

	// output register
	logic                out_valid_q;
	logic [PC_WIDTH-1:0] next_pc_q;
	logic [DATA_W-1:0]   wval_q;
	logic                fault_q;

	logic                accept;
	logic                finish_go;
	logic [TA_W-1:0]     td_in;
	logic [TA_W-1:0]     ta_in;
	logic [TA_W-1:0]     tb_in;
	logic [VA_W-1:0]     vs_in;
	logic [TA_W-1:0]     rd_addr_a;
	logic                clr_in_temps;
	logic                clr_in_vars;
	logic                tmp_we;
	logic [TA_W-1:0]     tmp_waddr;
	logic [DATA_W-1:0]   tmp_wdata;
	logic                var_we;
	logic [VA_W-1:0]     var_waddr;
	logic [DATA_W-1:0]   var_wdata;
	logic [DATA_W:0]     unit_x;
	logic [DATA_W:0]     unit_y;
	logic                unit_sub;
	logic [DATA_W:0]     unit_sum;
	logic [DATA_W-1:0]   rem_sh;
	logic                cmp_lt;
	logic                cmp_eq;
	logic                fix_neg;
	logic [PC_WIDTH-1:0] ld_pc;
	logic [DATA_W-1:0]   ld_val;
	logic                ld_fault;
	logic                ld_wr_temp;
	logic                ld_wr_var;

	assign in_ready      = (state_q == ST_IDLE);
	assign accept        = in_valid && in_ready;
	assign finish_go     = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign out_valid     = out_valid_q;
	assign next_pc       = next_pc_q;
	assign written_value = wval_q;
	assign fault         = fault_q;

	// index reduction on the request ports
	assign td_in = TA_W'(idx_mod(dest_temp, NUM_TEMPS));
	assign ta_in = TA_W'(idx_mod(src_temp_a, NUM_TEMPS));
	assign tb_in = TA_W'(idx_mod(src_temp_b, NUM_TEMPS));
	assign vs_in = VA_W'(idx_mod(var_slot, NUM_VARS));
	assign rd_addr_a = (mode_t'(mode) == MODE_ALU) ? ta_in : td_in;

	// write port muxing: clearing pass or instruction retire
	assign clr_in_temps = ({1'b0, clr_cnt_q} < TEMPS_LIM);
	assign clr_in_vars  = ({1'b0, clr_cnt_q} < VARS_LIM);
	always_comb begin
		if (state_q == ST_CLEAR) begin
			tmp_we    = clr_in_temps;
			tmp_waddr = clr_cnt_q[TA_W-1:0];
			tmp_wdata = '0;
			var_we    = clr_in_vars;
			var_waddr = clr_cnt_q[VA_W-1:0];
			var_wdata = '0;
		end else begin
			tmp_we    = finish_go && wr_temp_q;
			tmp_waddr = td_q;
			tmp_wdata = res_val_q;
			var_we    = finish_go && wr_var_q;
			var_waddr = vs_q;
			var_wdata = res_val_q;
		end
	end

	// temp file: one write, two registered reads
	always_ff @(posedge clk) begin
		if (tmp_we) begin
			temp_mem[tmp_waddr] <= tmp_wdata;
		end
		rd_a_q <= temp_mem[rd_addr_a];
		rd_b_q <= temp_mem[tb_in];
	end

	// variable store: one write, one registered read
	always_ff @(posedge clk) begin
		if (var_we) begin
			var_mem[var_waddr] <= var_wdata;
		end
		rd_v_q <= var_mem[vs_in];
	end

	// shared 33-bit add/subtract unit
	assign rem_sh = {acc_q[DATA_W-2:0], quo_q[DATA_W-1]};
	always_comb begin
		unit_x   = '0;
		unit_y   = '0;
		unit_sub = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				unit_x   = {rd_a_q[DATA_W-1], rd_a_q};
				unit_y   = {rd_b_q[DATA_W-1], rd_b_q};
				unit_sub = (op_q != OP_ADD);
			end
			ST_NEGA: begin
				unit_y   = {1'b0, a_q};
				unit_sub = 1'b1;
			end
			ST_NEGB: begin
				unit_y   = {1'b0, b_q};
				unit_sub = 1'b1;
			end
			ST_MUL: begin
				unit_x = {1'b0, acc_q};
				unit_y = quo_q[0] ? {1'b0, a_q} : '0;
			end
			ST_DIV: begin
				unit_x   = {1'b0, rem_sh};
				unit_y   = {1'b0, b_q};
				unit_sub = 1'b1;
			end
			ST_FIX: begin
				unit_y   = {1'b0, (op_q == OP_DIV) ? quo_q : acc_q};
				unit_sub = 1'b1;
			end
			default: begin
			end
		endcase
		unit_sum = unit_x + (unit_y ^ {(DATA_W+1){unit_sub}}) + (DATA_W+1)'(unit_sub);
	end

	// signed compare flags from the load-cycle difference
	assign cmp_lt  = unit_sum[DATA_W];
	assign cmp_eq  = (unit_sum[DATA_W-1:0] == '0);
	assign fix_neg = (op_q == OP_DIV) ? (sign_a_q ^ sign_b_q) : sign_a_q;

	// load-cycle result decode
	always_comb begin
		ld_pc      = pc_q + PC_WIDTH'(1);
		ld_val     = '0;
		ld_fault   = 1'b0;
		ld_wr_temp = 1'b0;
		ld_wr_var  = 1'b0;
		unique case (mode_q)
			MODE_STORE: begin
				ld_val    = rd_a_q;
				ld_wr_var = 1'b1;
			end
			MODE_LDVAR: begin
				ld_val     = rd_v_q;
				ld_wr_temp = 1'b1;
			end
			MODE_LDIMM: begin
				ld_val     = {1'b0, imm_q};
				ld_wr_temp = 1'b1;
			end
			MODE_LABEL: begin
			end
			MODE_GOTO: begin
				ld_pc = tgt_q;
			end
			MODE_BNZ: begin
				if (rd_a_q != '0) begin
					ld_pc = tgt_q;
				end
			end
			MODE_BZ: begin
				if (rd_a_q == '0) begin
					ld_pc = tgt_q;
				end
			end
			MODE_ALU: begin
				case (op_q) inside
					OP_ADD, OP_SUB: begin
						ld_val     = unit_sum[DATA_W-1:0];
						ld_wr_temp = 1'b1;
					end
					OP_MUL: begin
						ld_wr_temp = 1'b1;
					end
					OP_DIV, OP_MOD: begin
						if (rd_b_q == '0) begin
							ld_fault = 1'b1;
						end else begin
							ld_wr_temp = 1'b1;
						end
					end
					OP_LT: begin
						ld_val     = DATA_W'(cmp_lt);
						ld_wr_temp = 1'b1;
					end
					OP_GT: begin
						ld_val     = DATA_W'(!cmp_lt && !cmp_eq);
						ld_wr_temp = 1'b1;
					end
					OP_EQ: begin
						ld_val     = DATA_W'(cmp_eq);
						ld_wr_temp = 1'b1;
					end
					OP_NE: begin
						ld_val     = DATA_W'(!cmp_eq);
						ld_wr_temp = 1'b1;
					end
					OP_LE: begin
						ld_val     = DATA_W'(cmp_lt || cmp_eq);
						ld_wr_temp = 1'b1;
					end
					OP_GE: begin
						ld_val     = DATA_W'(!cmp_lt);
						ld_wr_temp = 1'b1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// request capture and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			op_q   <= alu_op_t'(alu_op);
			td_q   <= td_in;
			vs_q   <= vs_in;
			imm_q  <= immediate;
			pc_q   <= current_pc;
			tgt_q  <= jump_target;
		end
		unique case (state_q)
			ST_LOAD: begin
				res_pc_q    <= ld_pc;
				res_val_q   <= ld_val;
				res_fault_q <= ld_fault;
				wr_temp_q   <= ld_wr_temp;
				wr_var_q    <= ld_wr_var;
				a_q         <= rd_a_q;
				b_q         <= rd_b_q;
				sign_a_q    <= rd_a_q[DATA_W-1];
				sign_b_q    <= rd_b_q[DATA_W-1];
				acc_q       <= '0;
				quo_q       <= rd_b_q;
			end
			ST_NEGA: begin
				if (sign_a_q) begin
					a_q <= unit_sum[DATA_W-1:0];
				end
			end
			ST_NEGB: begin
				if (sign_b_q) begin
					b_q <= unit_sum[DATA_W-1:0];
				end
				quo_q <= a_q;
				acc_q <= '0;
			end
			ST_MUL: begin
				acc_q     <= unit_sum[DATA_W-1:0];
				a_q       <= {a_q[DATA_W-2:0], 1'b0};
				quo_q     <= {1'b0, quo_q[DATA_W-1:1]};
				res_val_q <= unit_sum[DATA_W-1:0];
			end
			ST_DIV: begin
				if (!unit_sum[DATA_W]) begin
					acc_q <= unit_sum[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b1};
				end else begin
					acc_q <= rem_sh;
					quo_q <= {quo_q[DATA_W-2:0], 1'b0};
				end
			end
			ST_FIX: begin
				if (fix_neg) begin
					res_val_q <= unit_sum[DATA_W-1:0];
				end else begin
					res_val_q <= (op_q == OP_DIV) ? quo_q : acc_q;
				end
			end
			default: begin
			end
		endcase
		// output register load
		if (finish_go) begin
			next_pc_q <= res_pc_q;
			wval_q    <= res_val_q;
			fault_q   <= res_fault_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid flag
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + CLR_W'(1);
					if (clr_cnt_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					if (mode_q == MODE_ALU && op_q == OP_MUL) begin
						state_q <= ST_MUL;
					end else if (mode_q == MODE_ALU && (op_q == OP_DIV || op_q == OP_MOD)
							&& rd_b_q != '0) begin
						state_q <= ST_NEGA;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_NEGA: begin
					state_q <= ST_NEGB;
				end
				ST_NEGB: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`ASSERT_IMPL(a_fault_no_value, out_valid && fault, written_value == '0, "fault result carries a value")
	`ASSERT_NEXT(a_accept_to_load, in_valid && in_ready, state_q == ST_LOAD, "accepted request did not start")
	`ASSERT_IMPL(a_clear_no_output, state_q == ST_CLEAR, !out_valid, "result presented during clearing pass")
	`ASSERT_NEXT(a_div_loop_end, state_q == ST_DIV && cnt_q == CNT_LAST, state_q == ST_FIX, "divide loop overran")

endmodule

// ===== tb/three_address_ir_executor_core_tb.sv =====
// ---------------------------------------------------------------------------
// three_address_ir_executor_core_tb
// Self-checking bench for the three-address executor. A queue of decoded
// instructions (a directed block of edge cases, then random programs over a
// small working set of temps) feeds a valid/ready driver; an in-bench copy of
// the temp file and variable store predicts next pc, written value and fault
// for every accepted request, and a monitor compares each result in order.
// ---------------------------------------------------------------------------
module three_address_ir_executor_core_tb
	import tair_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_INSTRS = 1700;
	localparam int QUIET_TAIL    = 150;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct packed {
		mode_t       mode;
		logic [3:0]  alu_op;
		logic [7:0]  dest_temp;
		logic [7:0]  src_a;
		logic [7:0]  src_b;
		logic [7:0]  var_slot;
		logic [30:0] imm;
		logic [15:0] pc;
		logic [15:0] target;
	} instr_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [31:0] wval;
		logic        fault;
	} retire_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [2:0]               mode = '0;
	logic [3:0]               alu_op = '0;
	logic [7:0]               dest_temp = '0;
	logic [7:0]               src_temp_a = '0;
	logic [7:0]               src_temp_b = '0;
	logic [7:0]               var_slot = '0;
	logic [30:0]              immediate = '0;
	logic [15:0]              current_pc = '0;
	logic [15:0]              jump_target = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [15:0]              next_pc;
	logic signed [DATA_W-1:0] written_value;
	logic                     fault;

	instr_t  program_q[$];
	retire_t retire_q[$];
	logic [31:0] temp_mem[256];
	logic [31:0] var_mem[256];

	instr_t  cur_instr;
	retire_t expect_res;
	retire_t pred_res;
	logic    in_taken = 1'b0;
	int      in_gap = 0;
	int      out_stall = 0;
	int      total_instrs = 0;
	int      accepted_count = 0;
	int      mismatch_count = 0;
	int      alu_count = 0;
	int      fault_count = 0;
	int      taken_count = 0;

	three_address_ir_executor_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .alu_op(alu_op), .dest_temp(dest_temp),
		.src_temp_a(src_temp_a), .src_temp_b(src_temp_b), .var_slot(var_slot),
		.immediate(immediate), .current_pc(current_pc), .jump_target(jump_target),
		.out_valid(out_valid), .out_ready(out_ready),
		.next_pc(next_pc), .written_value(written_value), .fault(fault)
	);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// idle probability changes every 128 requests, never in the tail
	function automatic int idle_pct(int shift);
		if (accepted_count + QUIET_TAIL >= total_instrs) begin
			return 0;
		end
		case (((accepted_count >> 7) + shift) % 4)
			0: return 0;
			1: return 15;
			2: return 40;
			default: return 70;
		endcase
	endfunction

	// execute one instruction against the bench copy of the stores
	function automatic retire_t execute_instr(instr_t ins);
		retire_t res;
		logic [31:0] a, b, r, ma, mb, q;
		logic wr;
		res.next_pc = ins.pc + 16'd1;
		res.wval = '0;
		res.fault = 1'b0;
		a = temp_mem[ins.src_a];
		b = temp_mem[ins.src_b];
		r = '0;
		wr = 1'b1;
		case (ins.mode)
			MODE_STORE: begin
				res.wval = temp_mem[ins.dest_temp];
				var_mem[ins.var_slot] = res.wval;
			end
			MODE_LDVAR: begin
				res.wval = var_mem[ins.var_slot];
				temp_mem[ins.dest_temp] = res.wval;
			end
			MODE_LDIMM: begin
				res.wval = {1'b0, ins.imm};
				temp_mem[ins.dest_temp] = res.wval;
			end
			MODE_LABEL: begin
			end
			MODE_GOTO: begin
				res.next_pc = ins.target;
			end
			MODE_BNZ: begin
				if (temp_mem[ins.dest_temp] != 32'd0) res.next_pc = ins.target;
			end
			MODE_BZ: begin
				if (temp_mem[ins.dest_temp] == 32'd0) res.next_pc = ins.target;
			end
			default: begin
				// magnitudes keep the most negative value as 2^31
				ma = a[31] ? 32'd0 - a : a;
				mb = b[31] ? 32'd0 - b : b;
				case (ins.alu_op)
					OP_ADD: r = a + b;
					OP_SUB: r = a - b;
					OP_MUL: r = a * b;
					OP_DIV, OP_MOD: begin
						if (b == 32'd0) begin
							res.fault = 1'b1;
							wr = 1'b0;
						end else if (ins.alu_op == OP_DIV) begin
							q = ma / mb;
							r = (a[31] ^ b[31]) ? 32'd0 - q : q;
						end else begin
							q = ma % mb;
							r = a[31] ? 32'd0 - q : q;
						end
					end
					OP_LT: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
					OP_GT: r = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
					OP_EQ: r = (a == b) ? 32'd1 : 32'd0;
					OP_NE: r = (a != b) ? 32'd1 : 32'd0;
					OP_LE: r = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
					OP_GE: r = ($signed(a) >= $signed(b)) ? 32'd1 : 32'd0;
					default: wr = 1'b0;
				endcase
				if (wr) begin
					temp_mem[ins.dest_temp] = r;
					res.wval = r;
				end
			end
		endcase
		return res;
	endfunction

	function automatic instr_t make_instr(mode_t m, logic [3:0] op, logic [7:0] d,
			logic [7:0] a, logic [7:0] b, logic [7:0] v, logic [30:0] imm,
			logic [15:0] pc, logic [15:0] tgt);
		instr_t ins;
		ins.mode = m;
		ins.alu_op = op;
		ins.dest_temp = d;
		ins.src_a = a;
		ins.src_b = b;
		ins.var_slot = v;
		ins.imm = imm;
		ins.pc = pc;
		ins.target = tgt;
		return ins;
	endfunction

	// mostly a small working set so values flow between instructions
	function automatic logic [7:0] pick_temp();
		if ($urandom_range(0, 9) < 8) return 8'($urandom_range(0, 7));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [30:0] pick_imm();
		case ($urandom_range(0, 9))
			0: return 31'd0;
			1: return 31'h7fffffff;
			2, 3, 4: return 31'($urandom_range(0, 16));
			5: return 31'd1 << $urandom_range(0, 30);
			default: return 31'($urandom());
		endcase
	endfunction

	function automatic instr_t random_instr();
		instr_t ins;
		int sel;
		ins.alu_op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
			: 4'($urandom_range(0, 10));
		ins.dest_temp = pick_temp();
		ins.src_a = pick_temp();
		ins.src_b = pick_temp();
		ins.var_slot = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
			: 8'($urandom_range(0, 255));
		ins.imm = pick_imm();
		ins.pc = 16'($urandom());
		ins.target = 16'($urandom());
		sel = $urandom_range(0, 99);
		if (sel < 20) ins.mode = MODE_LDIMM;
		else if (sel < 30) ins.mode = MODE_LDVAR;
		else if (sel < 40) ins.mode = MODE_STORE;
		else if (sel < 45) ins.mode = MODE_LABEL;
		else if (sel < 50) ins.mode = MODE_GOTO;
		else if (sel < 58) ins.mode = MODE_BNZ;
		else if (sel < 66) ins.mode = MODE_BZ;
		else ins.mode = MODE_ALU;
		return ins;
	endfunction

	// directed edge cases, then random instructions
	task automatic build_program();
		// extremes of the immediate and pc wrap
		program_q.push_back(make_instr(MODE_LDIMM, OP_ADD, 8'd0, 8'd0, 8'd0, 8'd0,
			31'h7fffffff, 16'h0000, 16'h0000));
		program_q.push_back(make_instr(MODE_LDIMM, OP_ADD, 8'd1, 8'd0, 8'd0, 8'd0,
			31'd0, 16'hffff, 16'h0000));
		program_q.push_back(make_instr(MODE_LDIMM, OP_ADD, 8'd255, 8'd0, 8'd0, 8'd0,
			31'd1, 16'h0002, 16'h0000));
		// wrap to the most negative value and to minus one
		program_q.push_back(make_instr(MODE_ALU, OP_ADD, 8'd2, 8'd0, 8'd255, 8'd0,
			31'd0, 16'h0003, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_SUB, 8'd4, 8'd1, 8'd255, 8'd0,
			31'd0, 16'h0004, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_MUL, 8'd8, 8'd0, 8'd0, 8'd0,
			31'd0, 16'h0005, 16'h0000));
		// overflowing division and its modulo
		program_q.push_back(make_instr(MODE_ALU, OP_DIV, 8'd5, 8'd2, 8'd4, 8'd0,
			31'd0, 16'h0006, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_MOD, 8'd6, 8'd2, 8'd4, 8'd0,
			31'd0, 16'h0007, 16'h0000));
		// division and modulo by zero
		program_q.push_back(make_instr(MODE_ALU, OP_DIV, 8'd7, 8'd0, 8'd1, 8'd0,
			31'd0, 16'h0008, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_MOD, 8'd7, 8'd0, 8'd1, 8'd0,
			31'd0, 16'h0009, 16'h0000));
		// negative dividend keeps its sign in the remainder
		program_q.push_back(make_instr(MODE_ALU, OP_MOD, 8'd9, 8'd2, 8'd0, 8'd0,
			31'd0, 16'h000a, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_DIV, 8'd9, 8'd2, 8'd0, 8'd0,
			31'd0, 16'h000b, 16'h0000));
		// signed comparisons
		program_q.push_back(make_instr(MODE_ALU, OP_LT, 8'd11, 8'd2, 8'd4, 8'd0,
			31'd0, 16'h000c, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_GT, 8'd11, 8'd2, 8'd4, 8'd0,
			31'd0, 16'h000d, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_EQ, 8'd11, 8'd4, 8'd4, 8'd0,
			31'd0, 16'h000e, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_NE, 8'd11, 8'd2, 8'd4, 8'd0,
			31'd0, 16'h000f, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_LE, 8'd11, 8'd4, 8'd4, 8'd0,
			31'd0, 16'h0010, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, OP_GE, 8'd11, 8'd2, 8'd4, 8'd0,
			31'd0, 16'h0011, 16'h0000));
		// unknown alu ops write nothing
		program_q.push_back(make_instr(MODE_ALU, 4'd11, 8'd0, 8'd0, 8'd0, 8'd0,
			31'd0, 16'h0012, 16'h0000));
		program_q.push_back(make_instr(MODE_ALU, 4'd15, 8'd255, 8'd255, 8'd255, 8'd0,
			31'd0, 16'h0013, 16'h0000));
		// variable store at both ends
		program_q.push_back(make_instr(MODE_STORE, OP_ADD, 8'd2, 8'd0, 8'd0, 8'd0,
			31'd0, 16'h0014, 16'h0000));
		program_q.push_back(make_instr(MODE_STORE, OP_ADD, 8'd4, 8'd0, 8'd0, 8'd255,
			31'd0, 16'h0015, 16'h0000));
		program_q.push_back(make_instr(MODE_LDVAR, OP_ADD, 8'd10, 8'd0, 8'd0, 8'd255,
			31'd0, 16'h0016, 16'h0000));
		// label, goto and both branches taken and not
		program_q.push_back(make_instr(MODE_LABEL, OP_ADD, 8'd0, 8'd0, 8'd0, 8'd0,
			31'd0, 16'h0017, 16'hffff));
		program_q.push_back(make_instr(MODE_GOTO, OP_ADD, 8'd0, 8'd0, 8'd0, 8'd0,
			31'd0, 16'h0018, 16'hffff));
		program_q.push_back(make_instr(MODE_BNZ, OP_ADD, 8'd4, 8'd0, 8'd0, 8'd0,
			31'd0, 16'h0019, 16'h1234));
		program_q.push_back(make_instr(MODE_BNZ, OP_ADD, 8'd1, 8'd0, 8'd0, 8'd0,
			31'd0, 16'h001a, 16'h1234));
		program_q.push_back(make_instr(MODE_BZ, OP_ADD, 8'd1, 8'd0, 8'd0, 8'd0,
			31'd0, 16'h001b, 16'h0000));
		program_q.push_back(make_instr(MODE_BZ, OP_ADD, 8'd4, 8'd0, 8'd0, 8'd0,
			31'd0, 16'hfffe, 16'h0000));
		for (int i = 0; i < RANDOM_INSTRS; i++) begin
			program_q.push_back(random_instr());
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (program_q.size() > 0) begin
				cur_instr = program_q.pop_front();
				mode        <= cur_instr.mode;
				alu_op      <= cur_instr.alu_op;
				dest_temp   <= cur_instr.dest_temp;
				src_temp_a  <= cur_instr.src_a;
				src_temp_b  <= cur_instr.src_b;
				var_slot    <= cur_instr.var_slot;
				immediate   <= cur_instr.imm;
				current_pc  <= cur_instr.pc;
				jump_target <= cur_instr.target;
				in_valid    <= 1'b1;
				if ($urandom_range(0, 99) < idle_pct(0)) in_gap = $urandom_range(1, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_stall > 0) begin
			out_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < idle_pct(2)) out_stall = $urandom_range(1, 9);
		end
	end

	// predict on every accepted request
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			pred_res = execute_instr(cur_instr);
			retire_q.push_back(pred_res);
			accepted_count++;
			if (cur_instr.mode == MODE_ALU) alu_count++;
			if (pred_res.fault) fault_count++;
			if (pred_res.next_pc != cur_instr.pc + 16'd1) taken_count++;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (retire_q.size() == 0) begin
				report_mismatch("result with no request pending", 32'(next_pc), 32'd0);
			end else begin
				expect_res = retire_q.pop_front();
				if (next_pc !== expect_res.next_pc) begin
					report_mismatch("next_pc", 32'(next_pc), 32'(expect_res.next_pc));
				end
				if (written_value !== expect_res.wval) begin
					report_mismatch("written_value", written_value, expect_res.wval);
				end
				if (fault !== expect_res.fault) begin
					report_mismatch("fault", 32'(fault), 32'(expect_res.fault));
				end
			end
		end
	end

	// run control
	initial begin
		build_program();
		total_instrs = program_q.size();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (accepted_count < total_instrs) @(posedge clk);
		while (retire_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d instructions, %0d of them alu ops", accepted_count, alu_count);
		$display("saw %0d divide faults and %0d taken jumps", fault_count, taken_count);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("timeout with %0d requests accepted", accepted_count);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/tair_pkg.sv
src/three_address_ir_executor_core.sv
tb/three_address_ir_executor_core_tb.sv
